### rtl/shdw32_pkg.sv
`timescale 1ns / 1ps

package shdw32_pkg;

    localparam int BLOCK_W       = 32;
    localparam int WORD_W        = 8;
    localparam int ROUND_KEY_W   = 32;
    localparam int KEY_W         = 64;
    localparam int KEY_REGS      = 7;
    localparam int ROUND_COUNT_W = 4;
    localparam int CFG_IDX_W     = 4;
    localparam int MAX_ROUNDS_DEF = 14;

    typedef logic [BLOCK_W-1:0]                block_t;
    typedef logic [WORD_W-1:0]                 word_t;
    typedef logic [ROUND_KEY_W-1:0]            round_key_t;
    typedef logic [KEY_REGS-1:0][KEY_W-1:0]    key_bank_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROUND_COUNT = 4'd0,
        REG_KEYS_FIRST  = 4'd1
    } cfg_reg_t;

    typedef struct packed {
        logic active;
        logic last;
    } round_ctl_t;

endpackage

### rtl/shdw32_round.sv
`timescale 1ns / 1ps

module shdw32_round
(
    input  shdw32_pkg::block_t     blk_in,
    input  shdw32_pkg::round_key_t rk,
    input  shdw32_pkg::round_ctl_t ctl,
    output shdw32_pkg::block_t     blk_out
);

    function automatic shdw32_pkg::word_t mix(input shdw32_pkg::word_t x);
        shdw32_pkg::word_t r1;
        shdw32_pkg::word_t r7;
        shdw32_pkg::word_t r2;
        r1 = {x[6:0], x[7]};
        r7 = {x[0], x[7:1]};
        r2 = {x[5:0], x[7:6]};
        return (r1 & r7) ^ r2;
    endfunction

    shdw32_pkg::word_t a;
    shdw32_pkg::word_t b;
    shdw32_pkg::word_t c;
    shdw32_pkg::word_t d;
    shdw32_pkg::word_t b1;
    shdw32_pkg::word_t d1;
    shdw32_pkg::word_t b3;
    shdw32_pkg::word_t d3;

    assign a = blk_in[31:24];
    assign b = blk_in[23:16];
    assign c = blk_in[15:8];
    assign d = blk_in[7:0];

    // first half, then words trade places before the second half
    assign b1 = b ^ mix(a) ^ rk[31:24];
    assign d1 = d ^ mix(c) ^ rk[23:16];
    assign b3 = a ^ mix(b1) ^ rk[15:8];
    assign d3 = c ^ mix(d1) ^ rk[7:0];

    always_comb
    begin
        if (!ctl.active)
        begin
            blk_out = blk_in;
        end
        else if (ctl.last)
        begin
            blk_out = {b1, b3, d1, d3};
        end
        else
        begin
            blk_out = {d1, b3, b1, d3};
        end
    end

endmodule

### rtl/shdw32_datapath.sv
`timescale 1ns / 1ps

module shdw32_datapath
#(
    parameter int MAX_ROUNDS = shdw32_pkg::MAX_ROUNDS_DEF,
    parameter int CNT_W      = $clog2(MAX_ROUNDS + 1)
)
(
    input  shdw32_pkg::block_t    blk_in,
    input  shdw32_pkg::key_bank_t keys,
    input  logic [CNT_W-1:0]      n_rounds,
    output shdw32_pkg::block_t    blk_out
);

    shdw32_pkg::block_t chain [MAX_ROUNDS+1];

    assign chain[0] = blk_in;

    for (genvar r = 0; r < MAX_ROUNDS; r++)
    begin : g_round
        shdw32_pkg::round_key_t rk;
        shdw32_pkg::round_ctl_t ctl;

        if ((r / 2) < shdw32_pkg::KEY_REGS)
        begin : g_key
            if ((r % 2) == 0)
            begin : g_even
                assign rk = keys[r/2][63:32];
            end
            else
            begin : g_odd
                assign rk = keys[r/2][31:0];
            end
        end
        else
        begin : g_nokey
            assign rk = '0;
        end

        assign ctl.active = CNT_W'(r) < n_rounds;
        assign ctl.last   = CNT_W'(r + 1) == n_rounds;

        shdw32_round u_round
        (
            .blk_in  (chain[r]),
            .rk      (rk),
            .ctl     (ctl),
            .blk_out (chain[r+1])
        );
    end

    assign blk_out = chain[MAX_ROUNDS];

endmodule

### rtl/arx_feistel_block_cipher_32_core.sv
`timescale 1ns / 1ps

// Channel   | Signals                              | Direction
// ----------+--------------------------------------+-----------
// input     | in_valid, in_stall, plaintext        | beat in
// output    | out_valid, out_stall, ciphertext     | beat out
// config    | wr_en, wr_index, wr_data             | write only
//
// One beat per cycle in and out while out_stall is low; each beat passes the input register, then the result register.
// All active rounds are unrolled between the two registers.
// in_stall rises only when both registers are full and out_stall holds the result.
// rst_n clears valids, round_count to 1 and all keys to zero.

module arx_feistel_block_cipher_32_core
#(
    parameter int MAX_ROUNDS = shdw32_pkg::MAX_ROUNDS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [shdw32_pkg::BLOCK_W-1:0]       plaintext,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [shdw32_pkg::BLOCK_W-1:0]       ciphertext,
    input  logic                                 wr_en,
    input  logic [shdw32_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [shdw32_pkg::KEY_W-1:0]         wr_data
);

    localparam int CNT_W = $clog2(MAX_ROUNDS + 1);

    logic [shdw32_pkg::ROUND_COUNT_W-1:0] round_count_reg;
    logic [shdw32_pkg::ROUND_COUNT_W-1:0] round_count_next;
    shdw32_pkg::key_bank_t                key_reg;
    shdw32_pkg::key_bank_t                key_next;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    shdw32_pkg::block_t pt_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    shdw32_pkg::block_t ct_reg;
    shdw32_pkg::block_t dp_out;

    logic [CNT_W-1:0] n_rounds;
    logic             s1_load;
    logic             s2_load;

    always_comb
    begin
        round_count_next = round_count_reg;
        key_next         = key_reg;
        if (wr_en)
        begin
            if (wr_index == shdw32_pkg::REG_ROUND_COUNT)
            begin
                round_count_next = wr_data[shdw32_pkg::ROUND_COUNT_W-1:0];
            end
            for (int i = 0; i < shdw32_pkg::KEY_REGS; i++)
            begin
                if (wr_index == shdw32_pkg::CFG_IDX_W'(shdw32_pkg::REG_KEYS_FIRST + i))
                begin
                    key_next[i] = wr_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= shdw32_pkg::ROUND_COUNT_W'(1);
            key_reg         <= '0;
        end
        else
        begin
            round_count_reg <= round_count_next;
            key_reg         <= key_next;
        end
    end

    // saturate the round count
    always_comb
    begin
        if (32'(round_count_reg) > MAX_ROUNDS)
        begin
            n_rounds = CNT_W'(MAX_ROUNDS);
        end
        else
        begin
            n_rounds = CNT_W'(round_count_reg);
        end
    end

    assign s2_load  = !out_valid_reg || !out_stall;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_stall = !s1_load;

    assign s1_valid_next  = s1_load ? in_valid : s1_valid_reg;
    assign out_valid_next = s2_load ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            pt_reg <= plaintext;
        end
        if (s2_load && s1_valid_reg)
        begin
            ct_reg <= dp_out;
        end
    end

    shdw32_datapath
    #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .CNT_W      (CNT_W)
    )
    u_datapath
    (
        .blk_in   (pt_reg),
        .keys     (key_reg),
        .n_rounds (n_rounds),
        .blk_out  (dp_out)
    );

    assign out_valid  = out_valid_reg;
    assign ciphertext = ct_reg;

    a_stall_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with room in the pipe");

    a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> s1_valid_reg)
        else $error("accepted beat lost at input register");

    a_s1_moves_to_s2 : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_load) |=> out_valid_reg)
        else $error("beat lost between stages");

    a_s1_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_load) |=> (s1_valid_reg && $stable(pt_reg)))
        else $error("held beat in input register changed");

    a_round_clamp : assert property (@(posedge clk) disable iff (!rst_n)
        32'(n_rounds) <= MAX_ROUNDS)
        else $error("round count above maximum");

endmodule

### test/arx_feistel_block_cipher_32_check.sv
`timescale 1ns / 1ps

module arx_feistel_block_cipher_32_check
    import shdw32_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  block_t               plaintext,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  block_t               ciphertext,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [KEY_W-1:0]     wr_data,
    output int                   pending,
    output int                   errors
);

    logic [ROUND_COUNT_W-1:0] rounds_cfg;
    key_bank_t                key_cfg;
    block_t                   ciphertext_q[$];
    block_t                   want_ct;
    int                       pending_count = 0;
    int                       mismatch_count = 0;

    assign pending = pending_count;
    assign errors  = mismatch_count;

    function automatic word_t round_mix(input word_t x);
        word_t r1;
        word_t r7;
        word_t r2;
        r1 = {x[6:0], x[7]};
        r7 = {x[0], x[7:1]};
        r2 = {x[5:0], x[7:6]};
        return (r1 & r7) ^ r2;
    endfunction

    function automatic block_t shadow_encrypt(input block_t pt,
                                              input logic [ROUND_COUNT_W-1:0] rc,
                                              input key_bank_t keys);
        word_t      a;
        word_t      b;
        word_t      c;
        word_t      d;
        word_t      t;
        round_key_t k;
        int         n;
        {a, b, c, d} = pt;
        n = (int'(rc) > MAX_ROUNDS_DEF) ? MAX_ROUNDS_DEF : int'(rc);
        for (int r = 0; r < n; r++)
        begin
            k = r[0] ? keys[r >> 1][31:0] : keys[r >> 1][63:32];
            b = b ^ round_mix(a) ^ k[31:24];
            d = d ^ round_mix(c) ^ k[23:16];
            t = a; a = b; b = t;
            t = c; c = d; d = t;
            b = b ^ round_mix(a) ^ k[15:8];
            d = d ^ round_mix(c) ^ k[7:0];
            if (r + 1 != n)
            begin
                t = a; a = c; c = t;
            end
        end
        return {a, b, c, d};
    endfunction

    task automatic flag_mismatch(input string what, input block_t got, input block_t want);
        $display("ERROR %0t: %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rounds_cfg = ROUND_COUNT_W'(1);
            key_cfg    = '0;
            ciphertext_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (ciphertext_q.size() == 0)
                    flag_mismatch("ciphertext beat with no block pending", ciphertext, 'x);
                else
                begin
                    want_ct = ciphertext_q.pop_front();
                    if (ciphertext !== want_ct)
                        flag_mismatch("ciphertext", ciphertext, want_ct);
                end
            end
            if (in_valid && !in_stall)
                ciphertext_q.push_back(shadow_encrypt(plaintext, rounds_cfg, key_cfg));
            if (wr_en)
            begin
                if (wr_index == REG_ROUND_COUNT)
                    rounds_cfg = wr_data[ROUND_COUNT_W-1:0];
                else if (int'(wr_index) >= int'(REG_KEYS_FIRST) &&
                         int'(wr_index) < int'(REG_KEYS_FIRST) + KEY_REGS)
                    key_cfg[int'(wr_index) - int'(REG_KEYS_FIRST)] = wr_data;
            end
        end
        pending_count <= ciphertext_q.size();
    end

endmodule

### test/arx_feistel_block_cipher_32_core_test.sv
`timescale 1ns / 1ps

module arx_feistel_block_cipher_32_core_test;

    import shdw32_pkg::*;

    typedef enum int {KEYS_RANDOM, KEYS_CLEAR, KEYS_FULL} key_fill_t;

    localparam int QUIET_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASES       = 12;
    localparam int PHASE_BLOCKS = 106;
    localparam int STRAY_FIRST  = int'(REG_KEYS_FIRST) + KEY_REGS;
    localparam int STRAY_LAST   = (1 << CFG_IDX_W) - 1;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    block_t               plaintext = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    block_t               ciphertext;
    logic                 wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index = '0;
    logic [KEY_W-1:0]     wr_data = '0;

    int   pending_blocks;
    int   mismatches;
    int   quiet_cycles = 0;
    logic calm = 1'b0;
    logic steady = 1'b0;
    int   hold_asks = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   stall_left = 0;

    block_t corner_blocks[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001,
                                 32'h00FF_00FF, 32'hFF00_FF00, 32'h7F7F_7F7F, 32'h0102_0408};

    always #5 clk = ~clk;

    arx_feistel_block_cipher_32_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .plaintext  (plaintext),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ciphertext (ciphertext),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data)
    );

    arx_feistel_block_cipher_32_check checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .plaintext  (plaintext),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .ciphertext (ciphertext),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .pending    (pending_blocks),
        .errors     (mismatches)
    );

    // receiver: long hold on request, otherwise short random stall bursts
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_served)
        begin
            hold_served <= hold_asks;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 9) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || wr_en)
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    task automatic put_reg(input int idx, input logic [KEY_W-1:0] value);
        wr_en    <= 1'b1;
        wr_index <= CFG_IDX_W'(idx);
        wr_data  <= value;
        @(posedge clk);
    endtask

    task automatic set_cipher(input logic [KEY_W-1:0] rc_word, input key_fill_t fill,
                              input int strays);
        logic [KEY_W-1:0] key_word;
        put_reg(int'(REG_ROUND_COUNT), rc_word);
        for (int i = 0; i < KEY_REGS; i++)
        begin
            case (fill)
                KEYS_CLEAR: key_word = '0;
                KEYS_FULL:  key_word = '1;
                default:    key_word = {$urandom, $urandom};
            endcase
            put_reg(int'(REG_KEYS_FIRST) + i, key_word);
        end
        for (int s = 0; s < strays; s++)
            put_reg((s == 0) ? STRAY_FIRST : (s == 1) ? STRAY_LAST :
                    $urandom_range(STRAY_FIRST, STRAY_LAST), {$urandom, $urandom});
        wr_en <= 1'b0;
    endtask

    task automatic send_block(input block_t pt);
        in_valid  <= 1'b1;
        plaintext <= pt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!calm && !steady && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_blocks != 0);
    endtask

    initial
    begin
        logic [KEY_W-1:0] rc_word;
        key_fill_t        fill;
        block_t           pt;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one round, clear keys
        foreach (corner_blocks[i])
            send_block(corner_blocks[i]);
        wait_drained();

        // zero rounds, upper data bits set to check masking
        set_cipher({60'hFFFF_FFFF_FFFF_FFF, 4'd0}, KEYS_RANDOM, 0);
        for (int i = 0; i < 4; i++)
            send_block(corner_blocks[i]);
        wait_drained();

        // rounds above the maximum saturate
        set_cipher({$urandom, 28'($urandom_range(0, 15)), 4'd15}, KEYS_FULL, 0);
        for (int i = 0; i < 4; i++)
            send_block(corner_blocks[i + 4]);
        wait_drained();

        // full rounds, writes to unknown indexes dropped
        set_cipher({60'd0, 4'd14}, KEYS_RANDOM, 2);
        for (int i = 0; i < 4; i++)
            send_block(corner_blocks[i * 2]);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       rc_word = {$urandom, $urandom};
                1:       rc_word = {$urandom, $urandom} | 64'hF;
                2:       rc_word = {$urandom, $urandom} & ~64'hF;
                3:       rc_word = 64'd1;
                default: rc_word = {$urandom, $urandom};
            endcase
            if (p == 0)
                rc_word = {rc_word[KEY_W-1:ROUND_COUNT_W], 4'd14};
            fill = (p == 4) ? KEYS_CLEAR : (p == 5) ? KEYS_FULL : KEYS_RANDOM;
            if (p == PHASES - 2)
                calm <= 1'b1;
            set_cipher(rc_word, fill, $urandom_range(0, 1));
            if (p == 3)
            begin
                // hold the receiver off while beats keep coming, so the core backs up
                steady = 1'b1;
                hold_asks <= hold_asks + 1;
            end
            for (int i = 0; i < PHASE_BLOCKS; i++)
            begin
                if ($urandom_range(0, 11) == 0)
                    pt = corner_blocks[$urandom_range(0, 7)];
                else
                    pt = $urandom;
                send_block(pt);
                if (i == 40)
                    steady = 1'b0;
            end
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
